// ----- hw/rtl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the servo frame receiver: item structs,
// result and event codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam logic [7:0] HdrByte         = 8'h55;
  localparam logic [7:0] LenMin          = 8'd3;
  localparam logic [7:0] LenMax          = 8'd7;
  localparam int         MboxDepth       = 10;
  localparam int         CaptureDepthDef = 16;

  typedef enum logic {
    OpByte = 1'b0,
    OpTake = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KindStatus = 2'd0,
    KindFrame  = 2'd1,
    KindNone   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    EvNone    = 2'd0,
    EvStored  = 2'd1,
    EvDropped = 2'd2,
    EvBadLen  = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    StIdle,
    StCopy,
    StEmit,
    StPlay
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    kind_e      result_kind;
    event_e     event_res;
    logic [7:0] frame_byte;
    logic [3:0] byte_index;
    logic [2:0] frame_length;
    logic       last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic accept_byte;
    logic accept_take;
    logic copy_step;
    logic emit_load;
    logic play_load;
  } sfr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_e  op;
    logic store_frame;
    logic mbox_full;
    logic copy_done;
    logic play_last;
    logic out_free;
  } sfr_sts_t;

endpackage

// ----- hw/rtl/sfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// sfr_ctrl
// Controller: sequences byte intake, capture-to-mailbox copy, status emit and
// frame read-out.
// ----------------------------------------------------------------------------
module sfr_ctrl
  import sfr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sfr_sts_t sts_i,
  output sfr_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (sts_i.op == OpByte) begin
            cmd_o.accept_byte = 1'b1;
            state_d = sts_i.store_frame ? StCopy : StEmit;
          end else begin
            cmd_o.accept_take = 1'b1;
            state_d = sts_i.mbox_full ? StPlay : StEmit;
          end
        end
      end
      StCopy: begin
        cmd_o.copy_step = 1'b1;
        if (sts_i.copy_done) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          state_d = StIdle;
        end
      end
      StPlay: begin
        if (sts_i.out_free) begin
          cmd_o.play_load = 1'b1;
          if (sts_i.play_last) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// ----- hw/rtl/sfr_datapath.sv -----
// ----------------------------------------------------------------------------
// sfr_datapath
// Reception state, capture memory, mailbox memory and the output register.
// ----------------------------------------------------------------------------
module sfr_datapath
  import sfr_pkg::*;
#(
  parameter int CAPTURE_DEPTH = CaptureDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  sfr_cmd_t  cmd_i,
  output sfr_sts_t  sts_o
);

  localparam int CapAw = $clog2(CAPTURE_DEPTH);

  // reception state
  logic       in_frame_q, header_seen_q;
  logic [3:0] pos_q;
  logic [2:0] exp_len_q;
  logic       mbox_full_q;
  logic [2:0] mbox_len_q;

  // per-item registers
  kind_e      kind_q;
  event_e     ev_q;
  logic [3:0] copy_idx_q;
  logic [3:0] play_idx_q;
  logic       wr_en_q;
  logic [3:0] wr_idx_q;
  logic [7:0] cap_rd_q;
  logic [7:0] mb_rd_q;

  logic       out_valid_q;
  out_item_t  out_q;

  logic [7:0] cap_mem [CAPTURE_DEPTH];
  logic [7:0] mb_mem  [MboxDepth];

  // next-state of reception for the byte on the input
  logic [7:0] rx_b;
  logic       hs_n, inf_n, active, cap_we, store;
  logic [3:0] pos_h, pos_n;
  logic [2:0] exp_n;
  event_e     ev_n;

  assign rx_b = in_data_i.rx_byte;

  always_comb begin
    hs_n   = header_seen_q;
    pos_h  = pos_q;
    active = in_frame_q;
    inf_n  = in_frame_q;
    exp_n  = exp_len_q;
    ev_n   = EvNone;
    cap_we = 1'b0;
    store  = 1'b0;
    if (!in_frame_q) begin
      if (rx_b == HdrByte) begin
        if (header_seen_q) begin
          hs_n   = 1'b0;
          active = 1'b1;
          pos_h  = 4'd1;
        end else begin
          hs_n = 1'b1;
        end
      end else begin
        hs_n  = 1'b0;
        pos_h = 4'd0;
      end
    end
    pos_n = pos_h;
    inf_n = active;
    if (active) begin
      cap_we = (32'(pos_h) < CAPTURE_DEPTH);
      pos_n  = pos_h + 4'd1;
      if (pos_h == 4'd3 && (rx_b < LenMin || rx_b > LenMax)) begin
        ev_n  = EvBadLen;
        exp_n = LenMin[2:0];
        inf_n = 1'b0;
      end else begin
        if (pos_h == 4'd3) begin
          exp_n = rx_b[2:0];
        end
        if (pos_n == {1'b0, exp_n} + 4'd3) begin
          if (!mbox_full_q) begin
            store = 1'b1;
            ev_n  = EvStored;
          end else begin
            ev_n = EvDropped;
          end
          inf_n = 1'b0;
        end
      end
    end
  end

  logic [3:0] mb_total;
  logic [3:0] play_nxt;
  logic       play_rd;
  logic       out_free;

  assign mb_total = {1'b0, mbox_len_q} + 4'd3;
  assign play_nxt = play_idx_q + 4'd1;
  assign play_rd  = cmd_i.play_load && (play_nxt < mb_total);
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q    <= 1'b0;
      header_seen_q <= 1'b0;
      pos_q         <= 4'd0;
      exp_len_q     <= LenMin[2:0];
      mbox_full_q   <= 1'b0;
      mbox_len_q    <= 3'd0;
      wr_en_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      wr_en_q <= cmd_i.copy_step;
      if (cmd_i.accept_byte) begin
        in_frame_q    <= inf_n;
        header_seen_q <= hs_n;
        pos_q         <= pos_n;
        exp_len_q     <= exp_n;
        if (store) begin
          mbox_full_q <= 1'b1;
          mbox_len_q  <= exp_n;
        end
      end
      if (cmd_i.accept_take) begin
        mbox_full_q <= 1'b0;
      end
      if (cmd_i.emit_load || cmd_i.play_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_byte) begin
      kind_q     <= KindStatus;
      ev_q       <= ev_n;
      copy_idx_q <= 4'd1;
    end
    if (cmd_i.accept_take) begin
      kind_q     <= KindNone;
      ev_q       <= EvNone;
      play_idx_q <= 4'd0;
    end
    if (cmd_i.copy_step) begin
      copy_idx_q <= copy_idx_q + 4'd1;
      wr_idx_q   <= copy_idx_q;
    end
    if (cmd_i.play_load) begin
      play_idx_q <= play_nxt;
    end
    if (cmd_i.emit_load) begin
      out_q.result_kind  <= kind_q;
      out_q.event_res    <= ev_q;
      out_q.frame_byte   <= 8'd0;
      out_q.byte_index   <= 4'd0;
      out_q.frame_length <= 3'd0;
      out_q.last         <= 1'b1;
    end else if (cmd_i.play_load) begin
      out_q.result_kind  <= KindFrame;
      out_q.event_res    <= EvNone;
      // byte 0 is the header byte and is not stored
      out_q.frame_byte   <= (play_idx_q == 4'd0) ? HdrByte : mb_rd_q;
      out_q.byte_index   <= play_idx_q;
      out_q.frame_length <= mbox_len_q;
      out_q.last         <= (play_nxt == mb_total);
    end
  end

  // capture memory: written on byte intake, read during the copy sweep
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_byte && cap_we) begin
      cap_mem[CapAw'(pos_h)] <= rx_b;
    end
    if (cmd_i.copy_step) begin
      cap_rd_q <= cap_mem[CapAw'(copy_idx_q)];
    end
  end

  // mailbox memory: written in the cycle after the capture read
  always_ff @(posedge clk_i) begin
    if (wr_en_q) begin
      mb_mem[wr_idx_q] <= cap_rd_q;
    end
    if (play_rd) begin
      mb_rd_q <= mb_mem[play_nxt];
    end
  end

  assign sts_o.op          = in_data_i.op;
  assign sts_o.store_frame = store;
  assign sts_o.mbox_full   = mbox_full_q;
  assign sts_o.copy_done   = (copy_idx_q == mb_total - 4'd1);
  assign sts_o.play_last   = (play_nxt == mb_total);
  assign sts_o.out_free    = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hw/rtl/servo_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// servo_frame_receiver
// Receive framer for 0x55 0x55 headed servo frames with a one-frame mailbox.
// ----------------------------------------------------------------------------
// Each input transfer is either a received byte or a take request. A byte
// returns one status transfer (event: none, stored, dropped, bad length)
// from the emit state through the output register; the byte that completes
// a frame while the mailbox is empty first runs a capture-to-mailbox copy of
// length+2 bytes (one byte per cycle through the capture memory read port).
// A take returns either one "no frame" transfer or length+3 frame-byte
// transfers, one per cycle while out_ready_i is high, paced by the mailbox
// read port. The block handles one item at a time and takes the next one as
// soon as the last result sits in the output register. No reset clearing
// pass: both memories are written before they are read.
// ----------------------------------------------------------------------------
module servo_frame_receiver
  import sfr_pkg::*;
#(
  parameter int CAPTURE_DEPTH = CaptureDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  sfr_cmd_t cmd;
  sfr_sts_t sts;

  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sfr_datapath #(
    .CAPTURE_DEPTH (CAPTURE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
